@@ src/vfg_pkg.sv @@
// shared constants, types and vowel formant table for the vowel formant gain core
package vfg_pkg;

    localparam int FRAC_BITS    = 12;
    localparam int FREQ_W       = 15;
    localparam int CFG_W        = 13;
    localparam int GAIN_OUT_W   = 15;
    localparam int NUM_FORMANTS = 3;
    localparam int NUM_VOWELS   = 5;
    localparam int VOWEL_W      = 3;

    localparam logic [CFG_W-1:0] ONE_CFG = CFG_W'(1 << FRAC_BITS);

    localparam int FQ_W     = FREQ_W + FRAC_BITS;
    localparam int CENTRE_W = 12 + FRAC_BITS;
    localparam int WIDTH_W  = 8 + FRAC_BITS;
    localparam int G100_W   = 7 + FRAC_BITS;
    localparam int GAIN_W   = FRAC_BITS + 1;
    // every width is at least 70 Hz, so d stays below 2^FQ_W / 64
    localparam int D_W      = FQ_W - 6;
    localparam int NUM1_W   = FQ_W + FRAC_BITS;
    localparam int SQ_W     = 2 * D_W;
    localparam int DEN2_W   = SQ_W + 1;
    localparam int NUM2_W   = GAIN_W + 2 * FRAC_BITS;
    localparam int TERM_W   = FRAC_BITS + 1;
    localparam int SUM_W    = FRAC_BITS + 3;
    localparam int BLEND_W  = 2 * FRAC_BITS + 4;

    // divide by 100 as a reciprocal multiply, exact over the whole gain range
    localparam int DIV100_SHIFT = G100_W + 7;
    localparam int DIV100_MUL   = ((1 << DIV100_SHIFT) + 99) / 100;
    localparam int GPROD_W      = 2 * G100_W + 1;

    // configuration register indexes
    localparam logic REG_VOWEL_POSITION = 1'b0;
    localparam logic REG_FORMANT_AMOUNT = 1'b1;

    typedef struct packed {
        logic [11:0] centre;
        logic [7:0]  bw;
        logic [6:0]  g100;
    } formant_t;

    typedef struct packed {
        logic [CENTRE_W-1:0] centre;
        logic [WIDTH_W-1:0]  width;
        logic [G100_W-1:0]   g100;
    } lane_param_t;

    // centre Hz, width Hz, gain in hundredths; vowels A E I O U
    localparam formant_t VOWEL_TABLE [NUM_VOWELS][NUM_FORMANTS] = '{
        '{'{12'd730, 8'd90, 7'd100}, '{12'd1090, 8'd110, 7'd50}, '{12'd2440, 8'd140, 7'd22}},
        '{'{12'd530, 8'd80, 7'd100}, '{12'd1840, 8'd120, 7'd42}, '{12'd2480, 8'd150, 7'd30}},
        '{'{12'd270, 8'd70, 7'd100}, '{12'd2290, 8'd130, 7'd30}, '{12'd3010, 8'd160, 7'd20}},
        '{'{12'd570, 8'd80, 7'd100}, '{12'd840,  8'd100, 7'd55}, '{12'd2410, 8'd140, 7'd14}},
        '{'{12'd300, 8'd70, 7'd100}, '{12'd870,  8'd100, 7'd35}, '{12'd2240, 8'd140, 7'd10}}
    };

endpackage

@@ src/vfg_divider.sv @@
// pipelined restoring divider, one quotient bit per stage
module vfg_divider #(
    parameter int NUM_W = vfg_pkg::NUM1_W,
    parameter int DEN_W = vfg_pkg::WIDTH_W,
    parameter int Q_W   = vfg_pkg::D_W
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             out_valid,
    output logic [Q_W-1:0]   quot
);

    logic [DEN_W-1:0] rem_reg   [Q_W];
    logic [Q_W-1:0]   lq_reg    [Q_W];
    logic [DEN_W-1:0] den_reg   [Q_W];
    logic             valid_reg [Q_W];

    for (genvar s = 0; s < Q_W; s++) begin : g_stage
        logic [DEN_W-1:0] prev_rem;
        logic [Q_W-1:0]   prev_lq;
        logic [DEN_W-1:0] prev_den;
        logic             prev_valid;
        logic [DEN_W:0]   trial;
        logic             ge;
        logic [DEN_W-1:0] rem_next;
        logic [Q_W-1:0]   lq_next;

        if (s == 0) begin : g_first
            // quotient fits Q_W bits, so the top numerator bits are below den
            assign prev_rem   = DEN_W'(num >> Q_W);
            assign prev_lq    = num[Q_W-1:0];
            assign prev_den   = den;
            assign prev_valid = in_valid;
        end
        else begin : g_next
            assign prev_rem   = rem_reg[s-1];
            assign prev_lq    = lq_reg[s-1];
            assign prev_den   = den_reg[s-1];
            assign prev_valid = valid_reg[s-1];
        end

        always_comb
        begin
            trial    = {prev_rem, prev_lq[Q_W-1]};
            ge       = (trial >= {1'b0, prev_den});
            rem_next = ge ? DEN_W'(trial - {1'b0, prev_den}) : trial[DEN_W-1:0];
            lq_next  = {prev_lq[Q_W-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else
            begin
                valid_reg[s] <= prev_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[s] <= rem_next;
            lq_reg[s]  <= lq_next;
            den_reg[s] <= prev_den;
        end
    end

    assign out_valid = valid_reg[Q_W-1];
    assign quot      = lq_reg[Q_W-1];

endmodule

@@ src/vfg_formant.sv @@
// one formant lane: gain rounding, distance, two dividers and the resonance term
module vfg_formant (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [vfg_pkg::FQ_W-1:0]      f_q,
    input  vfg_pkg::lane_param_t          prm,
    output logic                          out_valid,
    output logic [vfg_pkg::TERM_W-1:0]    term
);

    localparam int FB = vfg_pkg::FRAC_BITS;

    logic                          s2_valid_reg;
    logic [vfg_pkg::FQ_W-1:0]      diff_reg;
    logic [vfg_pkg::WIDTH_W-1:0]   width_reg;
    logic [vfg_pkg::GAIN_W-1:0]    gain_reg;

    logic [vfg_pkg::FQ_W-1:0]      centre_ext;
    logic [vfg_pkg::FQ_W-1:0]      diff_next;
    logic [vfg_pkg::G100_W-1:0]    grnd;
    logic [vfg_pkg::GPROD_W-1:0]   gprod;
    logic [vfg_pkg::GAIN_W-1:0]    gain_next;

    always_comb
    begin
        centre_ext = vfg_pkg::FQ_W'(prm.centre);
        diff_next  = (f_q >= centre_ext) ? f_q - centre_ext : centre_ext - f_q;
        // round to nearest, then divide by 100
        grnd       = prm.g100 + vfg_pkg::G100_W'(50);
        gprod      = vfg_pkg::GPROD_W'(grnd) * vfg_pkg::GPROD_W'(vfg_pkg::DIV100_MUL);
        gain_next  = vfg_pkg::GAIN_W'(gprod >> vfg_pkg::DIV100_SHIFT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        diff_reg  <= diff_next;
        width_reg <= prm.width;
        gain_reg  <= gain_next;
    end

    // d = diff * ONE / width
    logic                      d_valid;
    logic [vfg_pkg::D_W-1:0]   d_q;

    vfg_divider #(
        .NUM_W (vfg_pkg::NUM1_W),
        .DEN_W (vfg_pkg::WIDTH_W),
        .Q_W   (vfg_pkg::D_W)
    ) u_div_d (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid_reg),
        .num       ({diff_reg, FB'(0)}),
        .den       (width_reg),
        .out_valid (d_valid),
        .quot      (d_q)
    );

    // gain rides alongside the distance divider
    logic [vfg_pkg::GAIN_W-1:0] gdly_reg [vfg_pkg::D_W];

    always_ff @(posedge clk)
    begin
        gdly_reg[0] <= gain_reg;
        for (int i = 1; i < vfg_pkg::D_W; i++)
        begin
            gdly_reg[i] <= gdly_reg[i-1];
        end
    end

    logic                         s3_valid_reg;
    logic [vfg_pkg::SQ_W-1:0]     sq_reg;
    logic [vfg_pkg::GAIN_W-1:0]   gain3_reg;
    logic                         s4_valid_reg;
    logic [vfg_pkg::DEN2_W-1:0]   den2_reg;
    logic [vfg_pkg::NUM2_W-1:0]   num2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= d_valid;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_reg    <= vfg_pkg::SQ_W'(d_q) * vfg_pkg::SQ_W'(d_q);
        gain3_reg <= gdly_reg[vfg_pkg::D_W-1];
        den2_reg  <= (vfg_pkg::DEN2_W'(1) << (2 * FB)) + vfg_pkg::DEN2_W'(sq_reg);
        num2_reg  <= {gain3_reg, (2 * FB)'(0)};
    end

    // term = (gain << 2*FB) / (ONE*ONE + d*d)
    vfg_divider #(
        .NUM_W (vfg_pkg::NUM2_W),
        .DEN_W (vfg_pkg::DEN2_W),
        .Q_W   (vfg_pkg::TERM_W)
    ) u_div_term (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s4_valid_reg),
        .num       (num2_reg),
        .den       (den2_reg),
        .out_valid (out_valid),
        .quot      (term)
    );

endmodule

@@ src/vowel_formant_gain_core.sv @@
// top level of the vowel formant gain core: config, interpolation, lanes, blend
//
// vowel formant gain core: takes one partial frequency in whole Hz per beat and
// returns a Q12 gain (4096 is unity, at most 4.0) that imitates a sung vowel.
// the block is fully pipelined: it takes a new beat on every clock cycle, busy
// is never raised, and each result is strobed by gain_valid for one cycle;
// the receiver cannot stall, so the result must be taken when the strobe is
// high. the pipeline is made of the two restoring dividers in each formant
// lane (21 stages for the normalized distance, 13 for the resonance term)
// plus seven stages of interpolation, distance, squaring, summing and
// blending. the three formants run in parallel lanes.
// write vowel_position (index 0) and formant_amount (index 1) only while no
// beat is in flight; both reset to 0, so the core gives unity gain after reset.
module vowel_formant_gain_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [vfg_pkg::FREQ_W-1:0]        freq_hz,
    input  logic                              cfg_wr_en,
    input  logic                              cfg_index,
    input  logic [vfg_pkg::CFG_W-1:0]         cfg_wdata,
    output logic                              gain_valid,
    output logic [vfg_pkg::GAIN_OUT_W-1:0]    gain_q12
);

    localparam int FB  = vfg_pkg::FRAC_BITS;
    localparam int CW  = vfg_pkg::CFG_W;
    localparam int NF  = vfg_pkg::NUM_FORMANTS;
    localparam int VW  = vfg_pkg::VOWEL_W;
    localparam int X_W = CW + 2;

    // pipeline never stalls, so every start beat is taken
    assign busy = 1'b0;

    // configuration registers
    logic [CW-1:0] vowel_position_reg;
    logic [CW-1:0] formant_amount_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vowel_position_reg <= '0;
            formant_amount_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                vfg_pkg::REG_VOWEL_POSITION: vowel_position_reg <= cfg_wdata;
                vfg_pkg::REG_FORMANT_AMOUNT: formant_amount_reg <= cfg_wdata;
                default:                     vowel_position_reg <= vowel_position_reg;
            endcase
        end
    end

    // vowel pick: position clamped to one, scaled by four, split into vowel and fraction
    logic [CW-1:0]  pos_clamped;
    logic [X_W-1:0] pos_x4;
    logic [VW-1:0]  vowel_lo;
    logic [VW-1:0]  vowel_hi;
    logic [CW-1:0]  frac_hi;
    logic [CW-1:0]  frac_lo;

    always_comb
    begin
        pos_clamped = (vowel_position_reg > vfg_pkg::ONE_CFG) ? vfg_pkg::ONE_CFG
                                                              : vowel_position_reg;
        pos_x4      = {pos_clamped, 2'b00};
        vowel_lo    = pos_x4[FB+VW-1:FB];
        vowel_hi    = (vowel_lo < VW'(vfg_pkg::NUM_VOWELS - 1)) ? vowel_lo + VW'(1) : vowel_lo;
        frac_hi     = CW'(pos_x4[FB-1:0]);
        frac_lo     = vfg_pkg::ONE_CFG - frac_hi;
    end

    // stage 1: linear interpolation of every formant parameter
    logic                        s1_valid_reg;
    logic [vfg_pkg::FQ_W-1:0]    fq_reg;
    vfg_pkg::lane_param_t        prm_reg  [NF];
    vfg_pkg::lane_param_t        prm_next [NF];

    always_comb
    begin
        for (int i = 0; i < NF; i++)
        begin
            prm_next[i].centre =
                vfg_pkg::CENTRE_W'(vfg_pkg::VOWEL_TABLE[vowel_lo][i].centre) *
                vfg_pkg::CENTRE_W'(frac_lo) +
                vfg_pkg::CENTRE_W'(vfg_pkg::VOWEL_TABLE[vowel_hi][i].centre) *
                vfg_pkg::CENTRE_W'(frac_hi);
            prm_next[i].width =
                vfg_pkg::WIDTH_W'(vfg_pkg::VOWEL_TABLE[vowel_lo][i].bw) *
                vfg_pkg::WIDTH_W'(frac_lo) +
                vfg_pkg::WIDTH_W'(vfg_pkg::VOWEL_TABLE[vowel_hi][i].bw) *
                vfg_pkg::WIDTH_W'(frac_hi);
            prm_next[i].g100 =
                vfg_pkg::G100_W'(vfg_pkg::VOWEL_TABLE[vowel_lo][i].g100) *
                vfg_pkg::G100_W'(frac_lo) +
                vfg_pkg::G100_W'(vfg_pkg::VOWEL_TABLE[vowel_hi][i].g100) *
                vfg_pkg::G100_W'(frac_hi);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start & ~busy;
        end
    end

    always_ff @(posedge clk)
    begin
        fq_reg  <= {freq_hz, FB'(0)};
        prm_reg <= prm_next;
    end

    // three formant lanes in parallel, all of equal latency
    logic                          lane_valid [NF];
    logic [vfg_pkg::TERM_W-1:0]    lane_term  [NF];

    for (genvar g = 0; g < NF; g++) begin : g_lane
        vfg_formant u_formant (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (s1_valid_reg),
            .f_q       (fq_reg),
            .prm       (prm_reg[g]),
            .out_valid (lane_valid[g]),
            .term      (lane_term[g])
        );
    end

    // sum of the terms, capped at four
    localparam logic [vfg_pkg::SUM_W-1:0] SUM_CAP = vfg_pkg::SUM_W'(4 << FB);

    logic                        sum_valid_reg;
    logic [vfg_pkg::SUM_W-1:0]   sum_reg;
    logic [vfg_pkg::SUM_W-1:0]   sum_raw;
    logic                        lanes_valid;

    always_comb
    begin
        sum_raw     = '0;
        lanes_valid = 1'b1;
        for (int i = 0; i < NF; i++)
        begin
            sum_raw     = sum_raw + vfg_pkg::SUM_W'(lane_term[i]);
            lanes_valid = lanes_valid & lane_valid[i];
        end
    end

    // blend with unity: ONE*(ONE-amount) + amount*sum
    logic [CW-1:0]                amount;
    logic                         blend_valid_reg;
    logic [vfg_pkg::BLEND_W-1:0]  blend_reg;

    always_comb
    begin
        amount = (formant_amount_reg > vfg_pkg::ONE_CFG) ? vfg_pkg::ONE_CFG : formant_amount_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_valid_reg   <= 1'b0;
            blend_valid_reg <= 1'b0;
            gain_valid      <= 1'b0;
        end
        else
        begin
            sum_valid_reg   <= lanes_valid;
            blend_valid_reg <= sum_valid_reg;
            gain_valid      <= blend_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg   <= (sum_raw > SUM_CAP) ? SUM_CAP : sum_raw;
        blend_reg <= (vfg_pkg::BLEND_W'(vfg_pkg::ONE_CFG) <<  0) *
                     vfg_pkg::BLEND_W'(vfg_pkg::ONE_CFG - amount) +
                     vfg_pkg::BLEND_W'(amount) * vfg_pkg::BLEND_W'(sum_reg);
        // zero amount bypasses to exact unity
        if (amount == '0)
        begin
            gain_q12 <= vfg_pkg::GAIN_OUT_W'(vfg_pkg::ONE_CFG);
        end
        else
        begin
            gain_q12 <= vfg_pkg::GAIN_OUT_W'((blend_reg + vfg_pkg::BLEND_W'(1 << (FB - 1))) >> FB);
        end
    end

endmodule
